### rtl/core/cle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_pkg
// Shared types and codes for the circular list engine.
// ----------------------------------------------------------------------------
package cle_pkg;

    typedef enum logic [2:0] {
        FN_INS_END   = 3'd0,
        FN_INS_FRONT = 3'd1,
        FN_INS_AFTER = 3'd2,
        FN_DEL_FRONT = 3'd3,
        FN_DEL_END   = 3'd4,
        FN_DEL_KEY   = 3'd5,
        FN_DISPLAY   = 3'd6,
        FN_NOP       = 3'd7
    } func_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NOT_FND  = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_WALK,
        S_APPLY,
        S_FIX,
        S_SHOW,
        S_OUT
    } state_t;

endpackage

### rtl/core/circular_list_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_list_engine_unit
// Circular singly linked list of signed 32-bit values in linked slots.
// ----------------------------------------------------------------------------
// Requests are taken one at a time. The engine stalls its input from the
// cycle after acceptance until the final result word of the request is
// taken, then accepts the next request in the following cycle. A full
// insert, an empty-list request and the unused code go straight to the
// result word. Insert after key and delete key read one slot per cycle
// while they search, up to the key or through all elements when the key
// is missing. Delete end walks to the element before the tail. Display
// reads one slot and then offers one word for each element. New elements
// take the lowest free slot, found from a used-slot bit vector.
module circular_list_engine_unit #(
    parameter int CAPACITY = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [2:0]            func,
    input  logic signed [31:0]    value,
    input  logic signed [31:0]    key,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            status,
    output logic signed [31:0]    data,
    output logic [5:0]            count,
    output logic                  last
);
    import cle_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    // slot memories, one read port each, registered read
    logic [31:0]   val_mem [CAPACITY];
    logic [AW-1:0] lnk_mem [CAPACITY];
    logic [31:0]   val_rd;
    logic [AW-1:0] lnk_rd;
    logic [AW-1:0] rd_addr;
    logic          val_we, lnk_we;
    logic [AW-1:0] val_wa, lnk_wa;
    logic [31:0]   val_wd;
    logic [AW-1:0] lnk_wd;

    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            val_mem[val_wa] <= val_wd;
        end
        if (lnk_we)
        begin
            lnk_mem[lnk_wa] <= lnk_wd;
        end
        val_rd <= val_mem[rd_addr];
        lnk_rd <= lnk_mem[rd_addr];
    end

    state_t          state_reg, state_next;
    func_t           func_reg;
    logic [31:0]     value_reg, key_reg;
    logic [CAPACITY-1:0] used_reg, used_next;
    logic [AW-1:0]   head_reg, head_next, tail_reg, tail_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [AW-1:0]   cur_reg, cur_next, prv_reg, prv_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic [1:0]      st_reg, st_next;
    logic [31:0]     dat_reg, dat_next;
    logic            last_reg, last_next;

    // lowest free slot
    logic [AW-1:0] free_slot;
    logic          full;
    always_comb
    begin
        free_slot = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_slot = AW'(i);
            end
        end
    end
    assign full = &used_reg;

    // walk conditions; val_rd/lnk_rd belong to cur_reg
    logic key_hit, walk_end, tail_walk_end;
    assign key_hit       = (val_rd == key_reg);
    assign walk_end      = (int'(idx_reg) + 1 >= int'(cnt_reg));
    assign tail_walk_end = (int'(idx_reg) + 3 >= int'(cnt_reg));

    // slot to unlink, its predecessor and its successor
    logic [AW-1:0] del_slot, del_pred, del_nxt;
    assign del_slot = (func_reg == FN_DEL_END) ? tail_reg : cur_reg;
    assign del_pred = (func_reg == FN_DEL_END) ? cur_reg  : prv_reg;
    assign del_nxt  = (func_reg == FN_DEL_END) ? head_reg : lnk_rd;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign status    = st_reg;
    assign data      = dat_reg;
    assign count     = 6'(cnt_reg);
    assign last      = last_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (in_valid) state_next = S_DECIDE;
            S_DECIDE:
            begin
                case (func_reg)
                    FN_INS_END, FN_INS_FRONT:
                        state_next = full ? S_OUT : S_FIX;
                    FN_INS_AFTER, FN_DEL_KEY:
                        state_next = (cnt_reg == '0) ? S_OUT : S_WALK;
                    FN_DEL_FRONT:
                        state_next = (cnt_reg == '0) ? S_OUT : S_APPLY;
                    FN_DEL_END:
                    begin
                        if (cnt_reg == '0) state_next = S_OUT;
                        else if (int'(cnt_reg) <= 2) state_next = S_APPLY;
                        else state_next = S_WALK;
                    end
                    FN_DISPLAY:
                        state_next = (cnt_reg == '0) ? S_OUT : S_SHOW;
                    default:
                        state_next = S_OUT;
                endcase
            end
            S_WALK:
            begin
                if (func_reg == FN_DEL_END)
                begin
                    if (tail_walk_end) state_next = S_APPLY;
                end
                else if (key_hit)
                    state_next = (func_reg == FN_INS_AFTER && full) ? S_OUT : S_APPLY;
                else if (walk_end) state_next = S_OUT;
            end
            S_APPLY:  state_next = (func_reg == FN_INS_AFTER) ? S_FIX : S_OUT;
            S_FIX:    state_next = S_OUT;
            S_SHOW:   state_next = S_OUT;
            S_OUT:
            begin
                if (!out_stall)
                    state_next = last_reg ? S_IDLE : S_SHOW;
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        used_next = used_reg; head_next = head_reg; tail_next = tail_reg;
        cnt_next = cnt_reg; cur_next = cur_reg; prv_next = prv_reg;
        idx_next = idx_reg; st_next = st_reg;
        dat_next = dat_reg; last_next = last_reg;
        rd_addr = cur_reg;
        val_we = 1'b0; val_wa = free_slot; val_wd = value_reg;
        lnk_we = 1'b0; lnk_wa = free_slot; lnk_wd = head_reg;
        case (state_reg)
            S_DECIDE:
            begin
                // start any walk at head; first read issued here
                cur_next = head_reg; prv_next = tail_reg; idx_next = '0;
                rd_addr = head_reg;
                st_next = ST_OK; dat_next = '0; last_next = 1'b1;
                case (func_reg)
                    FN_INS_END, FN_INS_FRONT:
                    begin
                        if (full)
                            st_next = ST_FULL;
                        else
                        begin
                            // write the new slot; predecessor link patched next
                            val_we = 1'b1; lnk_we = 1'b1;
                            used_next[free_slot] = 1'b1;
                            cnt_next = cnt_reg + CW'(1);
                            cur_next = free_slot;
                            if (cnt_reg == '0)
                            begin
                                lnk_wd = free_slot; prv_next = free_slot;
                                head_next = free_slot; tail_next = free_slot;
                            end
                            else
                            begin
                                lnk_wd = head_reg; prv_next = tail_reg;
                                if (func_reg == FN_INS_END) tail_next = free_slot;
                                else head_next = free_slot;
                            end
                        end
                    end
                    FN_INS_AFTER, FN_DEL_FRONT, FN_DEL_END, FN_DEL_KEY, FN_DISPLAY:
                    begin
                        if (cnt_reg == '0) st_next = ST_EMPTY;
                    end
                    default: ;
                endcase
            end
            S_WALK:
            begin
                if (func_reg == FN_DEL_END)
                begin
                    // advance toward the element before the tail
                    cur_next = lnk_rd; idx_next = idx_reg + CW'(1);
                    rd_addr = lnk_rd;
                end
                else if (key_hit)
                begin
                    if (func_reg == FN_INS_AFTER && full)
                        st_next = ST_FULL;
                end
                else if (walk_end)
                begin
                    st_next = ST_NOT_FND;
                end
                else
                begin
                    prv_next = cur_reg; cur_next = lnk_rd;
                    idx_next = idx_reg + CW'(1);
                    rd_addr = lnk_rd;
                end
            end
            S_APPLY:
            begin
                if (func_reg == FN_INS_AFTER)
                begin
                    // new slot takes the successor of the key slot
                    val_we = 1'b1; lnk_we = 1'b1; lnk_wd = lnk_rd;
                    used_next[free_slot] = 1'b1;
                    cnt_next = cnt_reg + CW'(1);
                    prv_next = cur_reg; cur_next = free_slot;
                    if (cur_reg == tail_reg) tail_next = free_slot;
                end
                else
                begin
                    // unlink and free the slot
                    used_next[del_slot] = 1'b0;
                    if (int'(cnt_reg) <= 1)
                    begin
                        cnt_next = '0; head_next = '0; tail_next = '0;
                    end
                    else
                    begin
                        lnk_we = 1'b1; lnk_wa = del_pred; lnk_wd = del_nxt;
                        if (del_slot == head_reg) head_next = del_nxt;
                        if (del_slot == tail_reg) tail_next = del_pred;
                        cnt_next = cnt_reg - CW'(1);
                    end
                end
            end
            S_FIX:
            begin
                // insert: patch predecessor link
                lnk_we = 1'b1; lnk_wa = prv_reg; lnk_wd = cur_reg;
            end
            S_SHOW:
            begin
                dat_next = val_rd; st_next = ST_OK;
                last_next = walk_end;
                cur_next = lnk_rd; idx_next = idx_reg + CW'(1);
                rd_addr = lnk_rd;
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            cnt_reg   <= '0;
            cur_reg   <= '0;
            prv_reg   <= '0;
            idx_reg   <= '0;
            st_reg    <= '0;
            dat_reg   <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            cnt_reg   <= cnt_next;
            cur_reg   <= cur_next;
            prv_reg   <= prv_next;
            idx_reg   <= idx_next;
            st_reg    <= st_next;
            dat_reg   <= dat_next;
            last_reg  <= last_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            func_reg  <= func_t'(func);
            value_reg <= value;
            key_reg   <= key;
        end
    end

    // a walk never runs past the element count
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WALK |-> idx_reg < cnt_reg)
        else $error("walk index past count");
    // count agrees with the used-slot vector while idle
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> $countones(used_reg) == int'(cnt_reg))
        else $error("count and used slots disagree");
    // a result word is offered only after work on an accepted request
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without request");

endmodule
